// ===== src/lfd_pkg.sv =====
// Shared constants and types for the range-sensor frame deframer.
package lfd_pkg;

    localparam logic [7:0]  HDR_BYTE     = 8'h59;
    localparam logic [3:0]  CSUM_POS     = 4'd8;
    localparam logic [3:0]  POS_DIST_LO  = 4'd2;
    localparam logic [3:0]  POS_DIST_HI  = 4'd3;

    localparam int          ADDR_W       = 3;
    localparam logic        REG_MIN_DIST = 1'b0;
    localparam logic        REG_MAX_DIST = 1'b1;

    localparam logic [15:0] MIN_DIST_RST = 16'd10;
    localparam logic [15:0] MAX_DIST_RST = 16'd1200;

    typedef enum logic [2:0] {
        PH_HUNT = 3'b001,
        PH_HDR2 = 3'b010,
        PH_BODY = 3'b100
    } t_phase;

    typedef struct packed {
        logic [15:0] min_dist;
        logic [15:0] max_dist;
    } t_cfg;

    typedef struct packed {
        logic        valid;
        logic [15:0] dist_cm;
    } t_evt;

endpackage

// ===== src/lidar_frame_deframer.sv =====
// Top level of the range-sensor serial frame deframer.
//
//  channel   direction  tdata / data             tuser
//  s_axis    in         [7:0] rx_byte            [0] overrun
//  m_axis    out        [15:0] distance_cm       -
//  apb       in/out     0x0 min_distance, 0x4 max_distance (16 bits each)
//
// One word is taken every cycle while s_axis_tready is high; the parser updates its
// state in the same cycle. A good-checksum frame gives a result after its checksum
// word is taken, through the parser event register, then the clamp/output register.
// Reset (synchronous, active low) restarts the hunt and empties both registers;
// clamp limits return to 10 and 1200.
// s_axis_tready falls only when both the event register and the output register
// hold a result while m_axis_tready is low.
module lidar_frame_deframer (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // slave stream
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    input  logic [7:0]                 s_axis_tdata,   // [7:0] rx_byte
    input  logic [0:0]                 s_axis_tuser,   // [0] overrun
    // master stream
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    output logic [15:0]                m_axis_tdata,   // [15:0] distance_cm
    // configuration
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [lfd_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);
    import lfd_pkg::*;

    t_cfg cfg;
    t_evt evt;
    logic evt_ready;
    logic in_accept;

    // Hold the input only while a finished event cannot move on.
    assign s_axis_tready = !evt.valid || evt_ready;
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    lfd_apb_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    lfd_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (in_accept),
        .i_byte      (s_axis_tdata),
        .i_overrun   (s_axis_tuser[0]),
        .i_evt_ready (evt_ready),
        .o_evt       (evt)
    );

    lfd_clamp_out u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_evt       (evt),
        .o_evt_ready (evt_ready),
        .o_valid     (m_axis_tvalid),
        .i_ready     (m_axis_tready),
        .o_dist      (m_axis_tdata)
    );

endmodule

// ===== src/lfd_apb_regs.sv =====
// APB register file holding the distance clamp limits.
module lfd_apb_regs (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [lfd_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready,
    output lfd_pkg::t_cfg              o_cfg
);
    import lfd_pkg::*;

    logic [15:0] r_min_dist;
    logic [15:0] r_max_dist;
    logic        wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_dist <= MIN_DIST_RST;
            r_max_dist <= MAX_DIST_RST;
        end else if (wr_en) begin
            if (paddr[2] == REG_MIN_DIST) begin
                r_min_dist <= pwdata[15:0];
            end else begin
                r_max_dist <= pwdata[15:0];
            end
        end
    end

    // Low address bits are don't-care: registers sit on word boundaries.
    always_comb begin
        if (paddr[2] == REG_MIN_DIST) begin
            prdata = {16'd0, r_min_dist};
        end else begin
            prdata = {16'd0, r_max_dist};
        end
    end

    assign o_cfg.min_dist = r_min_dist;
    assign o_cfg.max_dist = r_max_dist;

endmodule

// ===== src/lfd_parser.sv =====
// Header hunt, checksum and distance capture; registers a good-frame event.
module lfd_parser (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_accept,
    input  logic [7:0]    i_byte,
    input  logic          i_overrun,
    input  logic          i_evt_ready,
    output lfd_pkg::t_evt o_evt
);
    import lfd_pkg::*;

    t_phase      r_phase, n_phase;
    logic [3:0]  r_pos, n_pos;
    logic [7:0]  r_sum, n_sum;
    logic [7:0]  r_dist_lo, n_dist_lo;
    logic [7:0]  r_dist_hi, n_dist_hi;
    logic        r_evt_valid, n_evt_valid;
    logic [15:0] r_evt_dist, n_evt_dist;
    logic        good;

    always_comb begin
        n_phase     = r_phase;
        n_pos       = r_pos;
        n_sum       = r_sum;
        n_dist_lo   = r_dist_lo;
        n_dist_hi   = r_dist_hi;
        n_evt_dist  = r_evt_dist;
        good        = 1'b0;
        n_evt_valid = r_evt_valid && !i_evt_ready;

        if (i_accept) begin
            if (i_overrun) begin
                // drop the byte and restart the hunt
                n_phase = PH_HUNT;
                n_pos   = 4'd0;
                n_sum   = 8'd0;
            end else begin
                case (r_phase)
                    PH_HDR2: begin
                        if (i_byte == HDR_BYTE) begin
                            n_phase = PH_BODY;
                            n_pos   = POS_DIST_LO;
                            n_sum   = r_sum + i_byte;
                        end else begin
                            n_phase = PH_HUNT;
                            n_pos   = 4'd0;
                            n_sum   = 8'd0;
                        end
                    end
                    PH_BODY: begin
                        if (r_pos < CSUM_POS) begin
                            if (r_pos == POS_DIST_LO) begin
                                n_dist_lo = i_byte;
                            end
                            if (r_pos == POS_DIST_HI) begin
                                n_dist_hi = i_byte;
                            end
                            n_sum = r_sum + i_byte;
                            n_pos = r_pos + 4'd1;
                        end else begin
                            good    = (r_sum == i_byte);
                            n_phase = PH_HUNT;
                            n_pos   = 4'd0;
                            n_sum   = 8'd0;
                        end
                    end
                    default: begin
                        if (i_byte == HDR_BYTE) begin
                            n_phase = PH_HDR2;
                            n_pos   = 4'd1;
                            n_sum   = i_byte;
                        end
                    end
                endcase
            end
        end

        if (good) begin
            n_evt_valid = 1'b1;
            n_evt_dist  = {r_dist_hi, r_dist_lo};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_HUNT;
            r_pos       <= 4'd0;
            r_sum       <= 8'd0;
            r_evt_valid <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_pos       <= n_pos;
            r_sum       <= n_sum;
            r_evt_valid <= n_evt_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_dist_lo  <= n_dist_lo;
        r_dist_hi  <= n_dist_hi;
        r_evt_dist <= n_evt_dist;
    end

    assign o_evt.valid   = r_evt_valid;
    assign o_evt.dist_cm = r_evt_dist;

endmodule

// ===== src/lfd_clamp_out.sv =====
// Clamp of the frame distance and the output register of the result stream.
module lfd_clamp_out (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  lfd_pkg::t_cfg i_cfg,
    input  lfd_pkg::t_evt i_evt,
    output logic          o_evt_ready,
    output logic          o_valid,
    input  logic          i_ready,
    output logic [15:0]   o_dist
);
    import lfd_pkg::*;

    logic        r_valid;
    logic [15:0] r_dist;
    logic [15:0] clamped;

    // Inverted limits: a distance below the lower limit gives the lower limit, any other the upper.
    always_comb begin
        if (i_evt.dist_cm < i_cfg.min_dist) begin
            clamped = i_cfg.min_dist;
        end else if (i_evt.dist_cm > i_cfg.max_dist) begin
            clamped = i_cfg.max_dist;
        end else begin
            clamped = i_evt.dist_cm;
        end
    end

    assign o_evt_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_evt_ready) begin
            r_valid <= i_evt.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_evt_ready && i_evt.valid) begin
            r_dist <= clamped;
        end
    end

    assign o_valid = r_valid;
    assign o_dist  = r_dist;

endmodule

// ===== src/lfd_checker.sv =====
// Port-level checks for the frame deframer, bound to the top level.
module lfd_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       s_axis_tvalid,
    input logic                       s_axis_tready,
    input logic [0:0]                 s_axis_tuser,
    input logic                       m_axis_tvalid,
    input logic                       m_axis_tready,
    input logic [15:0]                m_axis_tdata
);

    // Input back-pressure only comes from a stalled, full output.
    a_tready_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))
        else $error("input stalled without a stalled output");

    // A new result follows a clean word taken at the input.
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |->
            ($past(s_axis_tvalid && s_axis_tready, 2) && !$past(s_axis_tuser[0], 2)))
        else $error("result without a checksum word two cycles before");

    // Hold a stalled result.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("stalled result changed or dropped");

    // Reset empties the output.
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

endmodule

bind lidar_frame_deframer lfd_checker u_lfd_checker (.*);
